// ===== rtl/lfbm_pkg.sv =====
// Shared types, constants and ROM tables for the LED frame brightness/mask block.
// No dependencies; imported by lfbm_pix_mem and led_frame_brightness_mask_top.
package lfbm_pkg;

   localparam int NUM_LEDS      = 18;
   localparam int NUM_MASKS     = 10;
   localparam int ROM_PIXELS    = 18;
   localparam int ROM_MASK_ROWS = 10;

   localparam int IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int CMP_W   = 8;
   localparam int COLOR_W = 24;

   localparam logic [COLOR_W-1:0] WHITE        = 24'hFFFFFF;
   localparam logic [7:0]         BRIGHT_RESET = 8'd10;
   localparam logic [7:0]         BRIGHT_STEP  = 8'd10;
   localparam logic [7:0]         BRIGHT_MAX   = 8'd255;
   localparam logic [7:0]         BRIGHT_FLOOR = 8'd2;
   localparam logic [3:0]         MASK_RESET   = 4'd1;

   typedef enum logic [2:0] {
      CMD_SET_PIXEL   = 3'd0,
      CMD_SET_ALL     = 3'd1,
      CMD_BRIGHT_UP   = 3'd2,
      CMD_BRIGHT_DOWN = 3'd3,
      CMD_SET_MASK    = 3'd4,
      CMD_LOAD_PRESET = 3'd5
   } cmd_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     addr;
      logic [COLOR_W-1:0]   data;
   } mem_wr_type;

   // Mask rows, pixel 0 in the leftmost (most significant) bit.
   localparam logic [ROM_PIXELS-1:0] MASK_ROM [ROM_MASK_ROWS] = '{
      18'b111111111111111111,
      18'b111101111111101111,
      18'b000111000000111000,
      18'b010101000010101000,
      18'b000101010000101010,
      18'b101010101101010101,
      18'b011110100110011001,
      18'b010010111010010111,
      18'b111101101111101101,
      18'b101101111101101111
   };

   // Preset pattern, pixel 0 first.
   localparam logic [COLOR_W-1:0] PRESET_ROM [ROM_PIXELS] = '{
      24'hA652AF, 24'h000000, 24'h5F79FF, 24'hF16B74, 24'h000000, 24'h21BCE5,
      24'hF9AA67, 24'hF3EB48, 24'h97E062, 24'hA652AF, 24'h000000, 24'h5F79FF,
      24'hF16B74, 24'h000000, 24'h21BCE5, 24'hF9AA67, 24'hF3EB48, 24'h97E062
   };

   // Rows without a pattern and pixels beyond the ROM are off.
   function automatic logic mask_bit(logic [3:0] m, logic [IDX_W-1:0] i);
      logic on;
      on = 1'b0;
      if (int'(m) < ROM_MASK_ROWS && int'(i) < ROM_PIXELS) begin
         on = MASK_ROM[int'(m)][ROM_PIXELS-1-int'(i)];
      end
      return on;
   endfunction

   // Pixels beyond the ROM are black.
   function automatic logic [COLOR_W-1:0] preset_color(logic [IDX_W-1:0] i);
      logic [COLOR_W-1:0] c;
      c = '0;
      if (int'(i) < ROM_PIXELS) begin
         c = PRESET_ROM[int'(i)];
      end
      return c;
   endfunction

   // floor(p / 255) for any 16-bit product of two bytes
   function automatic logic [7:0] div255(logic [15:0] p);
      logic [16:0] s;
      s = 17'(p) + 17'(p[15:8]) + 17'd1;
      return s[15:8];
   endfunction

endpackage

// ===== rtl/lfbm_pix_mem.sv =====
// Pixel color store: synchronous RAM, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as white. Uses lfbm_pkg.
module lfbm_pix_mem import lfbm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  mem_wr_type           wr,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic [COLOR_W-1:0]   rd_data
);

   logic [COLOR_W-1:0]  mem [NUM_LEDS];
   logic [NUM_LEDS-1:0] known_ff;
   logic [COLOR_W-1:0]  raw_ff;
   logic                raw_known_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff     <= '0;
         raw_known_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            known_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            raw_known_ff <= known_ff[rd_addr];
         end
      end
   end

   assign rd_data = raw_known_ff ? raw_ff : WHITE;

endmodule

// ===== rtl/led_frame_brightness_mask_top.sv =====
// LED frame controller: 18 RGB pixels, global brightness, ROM pixel masks.
// Pipeline: a command's pixel words pass the RAM read, product and output registers.
// Throughput: 18 pixel words per known command, one per cycle unless rsp_tready stalls
// the output; next command is taken once the last word of the frame is delivered.
// Rate is set by the 18-word frame sweep plus the three-stage pipe fill.
// Reset (synchronous, active high): pixels white, brightness 10, mask 1.
module led_frame_brightness_mask_top import lfbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: cmd[2:0], pixel_index[7:3], color[31:8], mask_sel[35:32], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp_tdata: led_index[4:0], led_color[28:5], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   // Command fields
   logic [2:0]         req_cmd;
   logic [4:0]         req_pix;
   logic [23:0]        req_color;
   logic [3:0]         req_sel;
   logic               req_fire;
   logic               req_known;

   assign req_cmd   = req_tdata[2:0];
   assign req_pix   = req_tdata[7:3];
   assign req_color = req_tdata[31:8];
   assign req_sel   = req_tdata[35:32];
   assign req_fire  = req_tvalid && req_tready;
   assign req_known = (req_cmd <= CMD_LOAD_PRESET);

   // Control and global state
   logic               busy_ff,   busy_in;
   cmd_type            cmd_ff;
   logic [4:0]         pix_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               masked_ff;
   logic [7:0]         bright_ff, bright_in;
   logic [3:0]         mask_ff,   mask_in;

   // Sweep issue counter
   logic [IDX_W-1:0]   cnt_ff;
   logic               issue_ff;

   // Stage 1: RAM read data; stage 2: channel products; output register
   logic               s1_valid_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic               s2_valid_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic               s2_on_ff;
   logic [15:0]        s2_prod_r_ff, s2_prod_g_ff, s2_prod_b_ff;
   logic               out_valid_ff;
   logic [4:0]         out_idx_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic               out_last_ff;

   logic               advance;
   logic               rd_en;
   logic [COLOR_W-1:0] rd_data;
   logic [COLOR_W-1:0] s1_color;
   logic               s1_write;
   logic               s1_on;
   mem_wr_type         mem_wr;
   logic [COLOR_W-1:0] scaled;
   logic               rsp_fire;

   assign req_tready = !busy_ff;
   assign advance    = !out_valid_ff || rsp_tready;
   assign rd_en      = advance && issue_ff;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Brightness and mask updates happen at accept, ahead of the sweep
   always_comb begin
      bright_in = bright_ff;
      mask_in   = mask_ff;
      if (req_fire) begin
         unique case (cmd_type'(req_cmd))
            CMD_BRIGHT_UP: begin
               if (9'(bright_ff) + 9'(BRIGHT_STEP) > 9'(BRIGHT_MAX)) begin
                  bright_in = BRIGHT_MAX;
               end else begin
                  bright_in = bright_ff + BRIGHT_STEP;
               end
            end
            CMD_BRIGHT_DOWN: begin
               if (bright_ff <= BRIGHT_STEP + 8'd1) begin
                  bright_in = BRIGHT_FLOOR;
               end else begin
                  bright_in = bright_ff - BRIGHT_STEP;
               end
            end
            CMD_SET_MASK, CMD_LOAD_PRESET: begin
               if (int'(req_sel) < NUM_MASKS) begin
                  mask_in = req_sel;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Busy from accept of a real command to delivery of its last pixel
   always_comb begin
      busy_in = busy_ff;
      if (rsp_fire && rsp_tlast) begin
         busy_in = 1'b0;
      end
      if (req_fire && req_known) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         bright_ff <= BRIGHT_RESET;
         mask_ff   <= MASK_RESET;
         issue_ff  <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         bright_ff <= bright_in;
         mask_ff   <= mask_in;
         if (req_fire && req_known) begin
            issue_ff <= 1'b1;
            cnt_ff   <= '0;
         end else if (rd_en) begin
            if (int'(cnt_ff) == NUM_LEDS - 1) begin
               issue_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= cmd_type'(req_cmd);
         pix_ff    <= req_pix;
         color_ff  <= req_color;
         masked_ff <= !(cmd_type'(req_cmd) == CMD_SET_PIXEL ||
                        cmd_type'(req_cmd) == CMD_SET_ALL);
      end
   end

   lfbm_pix_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   // Stage 1: new pixel value, write back, mask lookup
   always_comb begin
      s1_color = rd_data;
      s1_write = 1'b0;
      unique case (cmd_ff)
         CMD_SET_PIXEL: begin
            if (CMP_W'(pix_ff) == CMP_W'(s1_idx_ff)) begin
               s1_color = color_ff;
               s1_write = 1'b1;
            end
         end
         CMD_SET_ALL: begin
            s1_color = color_ff;
            s1_write = 1'b1;
         end
         CMD_LOAD_PRESET: begin
            s1_color = preset_color(s1_idx_ff);
            s1_write = 1'b1;
         end
         default: begin
         end
      endcase
      s1_on       = !masked_ff || mask_bit(mask_ff, s1_idx_ff);
      mem_wr.en   = advance && s1_valid_ff && s1_write;
      mem_wr.addr = s1_idx_ff;
      mem_wr.data = s1_color;
   end

   // Pipeline valids; whole pipe holds while the output word is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= issue_ff;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   assign scaled = {div255(s2_prod_r_ff), div255(s2_prod_g_ff), div255(s2_prod_b_ff)};

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_idx_ff    <= cnt_ff;
         s2_idx_ff    <= s1_idx_ff;
         s2_on_ff     <= s1_on;
         s2_prod_r_ff <= s1_color[23:16] * bright_ff;
         s2_prod_g_ff <= s1_color[15:8]  * bright_ff;
         s2_prod_b_ff <= s1_color[7:0]   * bright_ff;
         out_idx_ff   <= 5'(s2_idx_ff);
         out_color_ff <= s2_on_ff ? scaled : '0;
         out_last_ff  <= (int'(s2_idx_ff) == NUM_LEDS - 1);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_color_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
